// ----- sv/binaural_fir_downmix_assert.svh -----
// ----------------------------------------------------------------------------
// binaural_fir_downmix assertion macros
// Shared wrappers for the concurrent checks of the binaural downmix block.
// ----------------------------------------------------------------------------
`ifndef BINAURAL_FIR_DOWNMIX_ASSERT_SVH
`define BINAURAL_FIR_DOWNMIX_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define BFD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define BFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bfd_pkg
// Types and fixed constants of the binaural FIR downmix block.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int ACC_BITS    = ((2 * SAMPLE_BITS + 8) > 62) ? 62 : (2 * SAMPLE_BITS + 8);
    localparam int CMD_BITS    = 2;
    localparam int SPK_BITS    = 4;
    localparam int TAP_BITS    = 7;

    // Command codes of an input word
    typedef enum logic [CMD_BITS-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_STORE,
        ST_EMIT
    } state_t;

    // Input word
    typedef struct packed {
        logic [CMD_BITS-1:0]           cmd;
        logic [SPK_BITS-1:0]           speaker;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          speaker_active;
        logic                          last_speaker;
        logic [TAP_BITS-1:0]           tap;
        logic signed [SAMPLE_BITS-1:0] coef_left;
        logic signed [SAMPLE_BITS-1:0] coef_right;
    } in_t;

    // Result word
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          clipped;
    } out_t;

    // Control from the sequencer to the MAC unit
    typedef struct packed {
        logic vld;
        logic clr;
    } mac_ctrl_t;

endpackage

// ----- sv/bfd_mac.sv -----
// ----------------------------------------------------------------------------
// bfd_mac
// Dual multiply-accumulate unit: one registered product per ear, saturating
// accumulation into the frame accumulators, and round/saturate to output.
// ----------------------------------------------------------------------------
module bfd_mac (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  bfd_pkg::mac_ctrl_t                      ctrl,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0]  sig,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0]  coef_l,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0]  coef_r,
    output logic                                    busy,
    output bfd_pkg::out_t                           res
);
    import bfd_pkg::*;

    localparam logic [ACC_BITS:0] HALF = (ACC_BITS + 1)'(1) << (SAMPLE_BITS - 2);

    logic signed [PROD_BITS-1:0] prod_l_reg, prod_r_reg;
    logic                        prod_vld_reg;
    logic signed [ACC_BITS-1:0]  acc_l_reg, acc_r_reg;
    logic signed [ACC_BITS-1:0]  acc_l_next, acc_r_next;
    logic [SAMPLE_BITS:0]        fin_l, fin_r;

    // Add a product to an accumulator, clamping to the accumulator range
    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0]  a,
        input logic signed [PROD_BITS-1:0] p
    );
        logic [ACC_BITS:0] s;
        s = {a[ACC_BITS-1], a} + {{(ACC_BITS + 1 - PROD_BITS){p[PROD_BITS-1]}}, p};
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            return s[ACC_BITS] ? {1'b1, {(ACC_BITS - 1){1'b0}}}
                               : {1'b0, {(ACC_BITS - 1){1'b1}}};
        end
        return s[ACC_BITS-1:0];
    endfunction

    // Round half up, drop the fraction, saturate; clip flag in the top bit
    function automatic logic [SAMPLE_BITS:0] finish(
        input logic signed [ACC_BITS-1:0] a
    );
        logic [ACC_BITS:0] v;
        logic [ACC_BITS-2*SAMPLE_BITS+2:0] top;
        v   = {a[ACC_BITS-1], a} + HALF;
        top = v[ACC_BITS:2*SAMPLE_BITS-2];
        if (!(&top) && (|top)) begin
            return {1'b1, v[ACC_BITS] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                      : {1'b0, {(SAMPLE_BITS - 1){1'b1}}}};
        end
        return {1'b0, v[2*SAMPLE_BITS-2:SAMPLE_BITS-1]};
    endfunction

    // Register the products
    always_ff @(posedge aclk) begin
        prod_l_reg <= sig * coef_l;
        prod_r_reg <= sig * coef_r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.vld;
        end
    end

    // Accumulate, or drop the frame once it has been emitted
    always_comb begin
        acc_l_next = acc_l_reg;
        acc_r_next = acc_r_reg;
        if (ctrl.clr) begin
            acc_l_next = '0;
            acc_r_next = '0;
        end else if (prod_vld_reg) begin
            acc_l_next = sat_add(acc_l_reg, prod_l_reg);
            acc_r_next = sat_add(acc_r_reg, prod_r_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else begin
            acc_l_reg <= acc_l_next;
            acc_r_reg <= acc_r_next;
        end
    end

    // Finish both ears
    always_comb begin
        fin_l         = finish(acc_l_reg);
        fin_r         = finish(acc_r_reg);
        res.left_out  = fin_l[SAMPLE_BITS-1:0];
        res.right_out = fin_r[SAMPLE_BITS-1:0];
        res.clipped   = fin_l[SAMPLE_BITS] | fin_r[SAMPLE_BITS];
    end

    assign busy = prod_vld_reg;

endmodule

// ----- sv/binaural_fir_downmix.sv -----
// ----------------------------------------------------------------------------
// binaural_fir_downmix
// Per-speaker left/right FIR over a circular sample history, summed into one
// stereo frame that is rounded, saturated and emitted on the last speaker.
// Active sample word: the single read port walks one tap per cycle in MAC,
// then DRAIN waits for the last reads and STORE writes the new sample; a
// last-speaker word goes on through EMIT. Only IDLE takes a new word.
// Load, clear, inactive and ignored words are handled in IDLE (an inactive last word then emits).
// Reset and clear drop histories at once through per-speaker wrap flags.
// ----------------------------------------------------------------------------
`include "binaural_fir_downmix_assert.svh"

module binaural_fir_downmix #(
    parameter int NUM_SPEAKERS = 16,
    parameter int TAPS         = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bfd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bfd_pkg::out_t m_data
);
    import bfd_pkg::*;

    localparam int SW    = (NUM_SPEAKERS > 1) ? $clog2(NUM_SPEAKERS) : 1;
    localparam int TW    = $clog2(TAPS);
    localparam int DEPTH = NUM_SPEAKERS * TAPS;
    localparam int MW    = $clog2(DEPTH);

    // Sample history and coefficient stores
    logic signed [SAMPLE_BITS-1:0] hist_mem   [DEPTH];
    logic signed [SAMPLE_BITS-1:0] coef_l_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] coef_r_mem [DEPTH];

    // Per-speaker write pointer and wrap flag
    logic [TW-1:0] ptr_reg  [NUM_SPEAKERS];
    logic          wrap_reg [NUM_SPEAKERS];

    state_t                        state_reg, state_next;
    logic [TW-1:0]                 tap_cnt_reg, tap_cnt_next;
    logic [TW-1:0]                 hidx_reg, hidx_next;
    logic [SW-1:0]                 spk_idx_reg;
    logic [MW-1:0]                 base_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;

    logic                          rd_vld_reg, rd_ok_reg;
    logic signed [SAMPLE_BITS-1:0] hist_q_reg, coef_l_q_reg, coef_r_q_reg;

    logic                          m_valid_reg;
    out_t                          m_data_reg;

    logic          accept, issue, hist_we, coef_we, ptr_clr, emit, load_item;
    logic [SW-1:0] in_spk_idx, ptr_sel;
    logic          in_spk_ok, in_tap_ok;
    logic [TW-1:0] cur_ptr, p_new;
    logic          cur_wrap, rd_ok;
    logic [MW-1:0] rd_hist_addr, rd_coef_addr, st_addr, ld_addr;

    mac_ctrl_t                     mac_ctrl;
    logic                          mac_busy;
    logic signed [SAMPLE_BITS-1:0] mac_sig;
    out_t                          mac_res;

    // Decode the incoming word
    assign accept     = s_valid && s_ready;
    assign in_spk_idx = SW'(s_data.speaker);
    assign in_spk_ok  = 32'(s_data.speaker) < NUM_SPEAKERS;
    assign in_tap_ok  = 32'(s_data.tap) < TAPS;
    assign ld_addr    = MW'(32'(in_spk_idx) * TAPS) + MW'(TW'(s_data.tap));

    // One read port on the pointer table: incoming speaker when idle
    assign ptr_sel  = (state_reg == ST_IDLE) ? in_spk_idx : spk_idx_reg;
    assign cur_ptr  = ptr_reg[ptr_sel];
    assign cur_wrap = wrap_reg[ptr_sel];
    assign p_new    = (32'(cur_ptr) == TAPS - 1) ? '0 : cur_ptr + 1'b1;

    // An entry holds a real sample once written since the last clear
    assign rd_ok = cur_wrap || ((hidx_reg != '0) && (hidx_reg <= cur_ptr));

    assign rd_hist_addr = base_reg + MW'(hidx_reg);
    assign rd_coef_addr = base_reg + MW'(tap_cnt_reg);
    assign st_addr      = base_reg + MW'(p_new);

    // Sequencer: next state and strobes
    always_comb begin
        state_next   = state_reg;
        tap_cnt_next = tap_cnt_reg;
        hidx_next    = hidx_reg;
        s_ready      = 1'b0;
        issue        = 1'b0;
        hist_we      = 1'b0;
        coef_we      = 1'b0;
        ptr_clr      = 1'b0;
        emit         = 1'b0;
        load_item    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.cmd)
                        CMD_SAMPLE: begin
                            load_item = 1'b1;
                            if (s_data.speaker_active && in_spk_ok) begin
                                state_next   = ST_MAC;
                                tap_cnt_next = '0;
                                hidx_next    = cur_ptr;
                            end else if (s_data.last_speaker) begin
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_LOAD: begin
                            coef_we = in_spk_ok && in_tap_ok;
                        end
                        CMD_CLEAR: begin
                            ptr_clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MAC: begin
                issue        = 1'b1;
                tap_cnt_next = tap_cnt_reg + 1'b1;
                hidx_next    = (hidx_reg == '0) ? TW'(TAPS - 1) : hidx_reg - 1'b1;
                if (32'(tap_cnt_reg) == TAPS - 1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                hist_we    = 1'b1;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_cnt_reg <= '0;
            hidx_reg    <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_cnt_reg <= tap_cnt_next;
            hidx_reg    <= hidx_next;
            rd_vld_reg  <= issue;
        end
    end

    // Hold the word being worked on
    always_ff @(posedge aclk) begin
        if (accept && load_item) begin
            spk_idx_reg <= in_spk_idx;
            base_reg    <= MW'(32'(in_spk_idx) * TAPS);
            sample_reg  <= s_data.sample;
            last_reg    <= s_data.last_speaker;
        end
    end

    // Advance pointers and wrap flags; clear drops them all
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && ptr_clr)) begin
            for (int i = 0; i < NUM_SPEAKERS; i++) begin
                ptr_reg[i]  <= '0;
                wrap_reg[i] <= 1'b0;
            end
        end else if (hist_we) begin
            ptr_reg[spk_idx_reg] <= p_new;
            if (p_new == '0) begin
                wrap_reg[spk_idx_reg] <= 1'b1;
            end
        end
    end

    // History store: registered read, write of the new sample
    always_ff @(posedge aclk) begin
        hist_q_reg <= hist_mem[rd_hist_addr];
        rd_ok_reg  <= rd_ok;
        if (hist_we) begin
            hist_mem[st_addr] <= sample_reg;
        end
    end

    // Coefficient stores: registered read, load on command
    always_ff @(posedge aclk) begin
        coef_l_q_reg <= coef_l_mem[rd_coef_addr];
        coef_r_q_reg <= coef_r_mem[rd_coef_addr];
        if (accept && coef_we) begin
            coef_l_mem[ld_addr] <= s_data.coef_left;
            coef_r_mem[ld_addr] <= s_data.coef_right;
        end
    end

    // Shared MAC unit
    assign mac_sig      = rd_ok_reg ? hist_q_reg : '0;
    assign mac_ctrl.vld = rd_vld_reg;
    assign mac_ctrl.clr = emit;

    bfd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .sig     (mac_sig),
        .coef_l  (coef_l_q_reg),
        .coef_r  (coef_r_q_reg),
        .busy    (mac_busy),
        .res     (mac_res)
    );

    // Output register: load on emit, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= mac_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `BFD_ASSERT_SAME(a_idle_quiet, aclk, aresetn, s_ready, !rd_vld_reg && !mac_busy, "word taken while MAC pipeline busy")
    `BFD_ASSERT_SAME(a_store_quiet, aclk, aresetn, hist_we, !rd_vld_reg && !mac_busy, "history written while taps still in flight")
    `BFD_ASSERT_NEXT(a_emit_hold, aclk, aresetn, (state_reg == ST_EMIT) && m_valid_reg && !m_ready, state_reg == ST_EMIT, "result overwrote an untaken word")
    `BFD_ASSERT_SAME(a_tap_range, aclk, aresetn, state_reg == ST_MAC, (32'(tap_cnt_reg) < TAPS) && (32'(hidx_reg) < TAPS), "tap index out of range")

endmodule
